// ----- rtl/mmc_pkg.sv -----
`timescale 1ns / 1ps
// shared types, widths and codes for the three-axis min/max calibrator
// no dependencies; imported by every module of the block
package mmc_pkg;

	// field widths
	localparam int SAMPLE_WIDTH    = 16;
	localparam int SCALE_FRAC_BITS = 14;
	localparam int CORR_WIDTH      = SAMPLE_WIDTH + 2;
	localparam int GAIN_WIDTH      = SCALE_FRAC_BITS + 2;
	localparam int NUM_AXES        = 3;

	// fit arithmetic widths
	localparam int SUM_WIDTH  = SAMPLE_WIDTH + 2;
	localparam int NUM_WIDTH  = SUM_WIDTH + SCALE_FRAC_BITS;
	localparam int DEN_WIDTH  = SAMPLE_WIDTH + 2;
	localparam int PROD_WIDTH = SAMPLE_WIDTH + 1 + GAIN_WIDTH + 1;
	localparam int DCNT_WIDTH = $clog2(GAIN_WIDTH + 1);

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic signed [CORR_WIDTH-1:0]   corr_t;
	typedef logic [GAIN_WIDTH-1:0]          gain_t;

	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
	localparam corr_t   CORR_MAX   = {1'b0, {(CORR_WIDTH-1){1'b1}}};
	localparam corr_t   CORR_MIN   = {1'b1, {(CORR_WIDTH-1){1'b0}}};
	localparam gain_t   GAIN_ONE   = gain_t'(1 << SCALE_FRAC_BITS);
	localparam gain_t   GAIN_MAX   = {GAIN_WIDTH{1'b1}};

	// item modes
	typedef enum logic [1:0] {
		MODE_CORRECT = 2'd0,
		MODE_ACCUM   = 2'd1,
		MODE_START   = 2'd2,
		MODE_STOP    = 2'd3
	} mode_t;

	// axis select for the shared divider
	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_FIT_SUM,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_RESP
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic  capture;
		logic  mul;
		logic  accum;
		logic  start_cal;
		logic  fit_half;
		logic  fit_sum;
		logic  div_start;
		logic  div_write;
		logic  stop_flag;
		logic  load_out;
		axis_t axis;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		mode_t mode;
		logic  calibrating;
		logic  div_done;
		logic  out_free;
	} dp_sts_t;

endpackage

// ----- rtl/mmc_div.sv -----
`timescale 1ns / 1ps
// shared restoring divider for the scale fit, one quotient bit per cycle
// depends on mmc_pkg; saturates on zero divisor or overflow, clamps negatives to zero
module mmc_div import mmc_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [NUM_WIDTH-1:0] num,
	input  logic signed [DEN_WIDTH-1:0] den,
	output logic                        done,
	output gain_t                       quot
);

	logic [NUM_WIDTH-1:0]  num_mag_q;
	logic [DEN_WIDTH-1:0]  den_mag_q;
	logic                  den_zero_q;
	logic                  skip_q;
	logic                  chk_q;
	logic                  run_q;
	logic                  done_q;
	logic [DCNT_WIDTH-1:0] cnt_q;
	logic [DEN_WIDTH-1:0]  rem_q;
	gain_t                 lo_q;
	gain_t                 quot_q;

	logic [NUM_WIDTH-1:0]  num_abs;
	logic [DEN_WIDTH-1:0]  den_abs;
	logic                  ovf;
	logic [DEN_WIDTH:0]    trial;
	logic [DEN_WIDTH:0]    sub;
	logic                  ge;

	// magnitudes of the operands
	always_comb begin
		num_abs = num[NUM_WIDTH-1] ? NUM_WIDTH'(-num) : NUM_WIDTH'(num);
		den_abs = den[DEN_WIDTH-1] ? DEN_WIDTH'(-den) : DEN_WIDTH'(den);
	end

	// quotient would not fit the gain field
	assign ovf = {2'b00, num_mag_q} >= {den_mag_q, {GAIN_WIDTH{1'b0}}};

	// one restoring step
	always_comb begin
		trial = {rem_q, lo_q[GAIN_WIDTH-1]};
		sub   = trial - {1'b0, den_mag_q};
		ge    = trial >= {1'b0, den_mag_q};
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_q  <= 1'b0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			chk_q  <= start;
			done_q <= 1'b0;
			if (chk_q) begin
				if (den_zero_q || skip_q || ovf) begin
					done_q <= 1'b1;
				end else begin
					run_q <= 1'b1;
					cnt_q <= DCNT_WIDTH'(GAIN_WIDTH);
				end
			end
			if (run_q) begin
				cnt_q <= cnt_q - DCNT_WIDTH'(1);
				if (cnt_q == DCNT_WIDTH'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand, remainder and quotient registers
	always_ff @(posedge clk) begin
		if (start) begin
			num_mag_q  <= num_abs;
			den_mag_q  <= den_abs;
			den_zero_q <= (den == '0);
			skip_q     <= (num == '0) || (num[NUM_WIDTH-1] != den[DEN_WIDTH-1]);
		end
		if (chk_q) begin
			if (den_zero_q) begin
				quot_q <= GAIN_MAX;
			end else if (skip_q) begin
				quot_q <= '0;
			end else begin
				quot_q <= GAIN_MAX;
			end
			rem_q <= DEN_WIDTH'(num_mag_q[NUM_WIDTH-1:GAIN_WIDTH]);
			lo_q  <= num_mag_q[GAIN_WIDTH-1:0];
		end
		if (run_q) begin
			rem_q <= ge ? sub[DEN_WIDTH-1:0] : trial[DEN_WIDTH-1:0];
			lo_q  <= {lo_q[GAIN_WIDTH-2:0], ge};
			if (cnt_q == DCNT_WIDTH'(1)) begin
				quot_q <= {lo_q[GAIN_WIDTH-2:0], ge};
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ----- rtl/mmc_dpath.sv -----
`timescale 1ns / 1ps
// calibrator datapath: extremes, bias and scale state, correction multiply,
// fit arithmetic and the output register; depends on mmc_pkg and mmc_div
module mmc_dpath import mmc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts,
	input  logic [1:0]  mode,
	input  sample_t     sample_x,
	input  sample_t     sample_y,
	input  sample_t     sample_z,
	input  logic        out_ready,
	output logic        out_valid,
	output corr_t       corrected_x,
	output corr_t       corrected_y,
	output corr_t       corrected_z,
	output sample_t     offset_x_out,
	output sample_t     offset_y_out,
	output sample_t     offset_z_out,
	output gain_t       gain_x_out,
	output gain_t       gain_y_out,
	output gain_t       gain_z_out,
	output logic        busy_calibrating
);

	// captured beat
	mode_t   mode_q;
	sample_t smp_q [NUM_AXES];

	// calibration state
	sample_t least_q [NUM_AXES];
	sample_t most_q  [NUM_AXES];
	sample_t bias_q  [NUM_AXES];
	gain_t   scale_q [NUM_AXES];
	logic    cal_q;

	// working registers
	sample_t                      half_q [NUM_AXES];
	logic signed [SUM_WIDTH-1:0]  sum_q;
	logic signed [PROD_WIDTH-1:0] prod_q [NUM_AXES];

	// output register
	logic    out_valid_q;
	corr_t   corr_q  [NUM_AXES];
	sample_t offs_q  [NUM_AXES];
	gain_t   gain_q  [NUM_AXES];
	logic    busy_q;

	// combinational terms
	logic signed [SAMPLE_WIDTH:0]            cdiff    [NUM_AXES];
	logic signed [GAIN_WIDTH:0]              gain_s   [NUM_AXES];
	logic signed [PROD_WIDTH-1:0]            prod_d   [NUM_AXES];
	logic signed [SAMPLE_WIDTH:0]            ext_sum  [NUM_AXES];
	logic signed [SAMPLE_WIDTH:0]            ext_dif  [NUM_AXES];
	logic signed [SUM_WIDTH-1:0]             half_ext [NUM_AXES];
	logic signed [PROD_WIDTH-SCALE_FRAC_BITS-1:0] psh [NUM_AXES];
	logic [PROD_WIDTH-SCALE_FRAC_BITS-CORR_WIDTH:0] pup [NUM_AXES];
	corr_t                                   corr_d   [NUM_AXES];
	logic signed [SUM_WIDTH-1:0]             den_half;
	logic signed [DEN_WIDTH-1:0]             div_den;
	logic signed [NUM_WIDTH-1:0]             div_num;
	logic                                    div_done;
	gain_t                                   div_quot;

	// per-axis correction product, fit terms and saturation
	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			cdiff[i]    = {smp_q[i][SAMPLE_WIDTH-1], smp_q[i]}
				- {bias_q[i][SAMPLE_WIDTH-1], bias_q[i]};
			gain_s[i]   = {1'b0, scale_q[i]};
			prod_d[i]   = cdiff[i] * gain_s[i];
			ext_sum[i]  = {most_q[i][SAMPLE_WIDTH-1], most_q[i]}
				+ {least_q[i][SAMPLE_WIDTH-1], least_q[i]};
			ext_dif[i]  = {most_q[i][SAMPLE_WIDTH-1], most_q[i]}
				- {least_q[i][SAMPLE_WIDTH-1], least_q[i]};
			half_ext[i] = {{(SUM_WIDTH-SAMPLE_WIDTH){half_q[i][SAMPLE_WIDTH-1]}}, half_q[i]};
			psh[i]      = prod_q[i][PROD_WIDTH-1:SCALE_FRAC_BITS];
			pup[i]      = psh[i][PROD_WIDTH-SCALE_FRAC_BITS-1:CORR_WIDTH-1];
			if ((&pup[i]) || !(|pup[i])) begin
				corr_d[i] = psh[i][CORR_WIDTH-1:0];
			end else if (psh[i][PROD_WIDTH-SCALE_FRAC_BITS-1]) begin
				corr_d[i] = CORR_MIN;
			end else begin
				corr_d[i] = CORR_MAX;
			end
		end
	end

	// divider operands: sum of the half-ranges over three times the axis half-range
	always_comb begin
		den_half = half_ext[cmd.axis];
		div_den  = (den_half <<< 1) + den_half;
		div_num  = {sum_q, {SCALE_FRAC_BITS{1'b0}}};
	end

	mmc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// capture and working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q   <= mode_t'(mode);
			smp_q[0] <= sample_x;
			smp_q[1] <= sample_y;
			smp_q[2] <= sample_z;
		end
		for (int i = 0; i < NUM_AXES; i++) begin
			if (cmd.mul) begin
				prod_q[i] <= prod_d[i];
			end
			if (cmd.fit_half) begin
				half_q[i] <= ext_dif[i][SAMPLE_WIDTH:1];
			end
		end
		if (cmd.fit_sum) begin
			sum_q <= half_ext[0] + half_ext[1] + half_ext[2];
		end
	end

	// calibration state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				least_q[i] <= SAMPLE_MAX;
				most_q[i]  <= SAMPLE_MIN;
				bias_q[i]  <= '0;
				scale_q[i] <= GAIN_ONE;
			end
			cal_q <= 1'b0;
		end else begin
			for (int i = 0; i < NUM_AXES; i++) begin
				if (cmd.accum) begin
					if (smp_q[i] < least_q[i]) begin
						least_q[i] <= smp_q[i];
					end
					if (smp_q[i] > most_q[i]) begin
						most_q[i] <= smp_q[i];
					end
				end
				if (cmd.start_cal) begin
					least_q[i] <= SAMPLE_MAX;
					most_q[i]  <= SAMPLE_MIN;
				end
				if (cmd.fit_half) begin
					bias_q[i] <= ext_sum[i][SAMPLE_WIDTH:1];
				end
			end
			if (cmd.div_write) begin
				scale_q[cmd.axis] <= div_quot;
			end
			if (cmd.start_cal) begin
				cal_q <= 1'b1;
			end else if (cmd.stop_flag) begin
				cal_q <= 1'b0;
			end
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output beat payload
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				corr_q[i] <= (mode_q == MODE_CORRECT) ? corr_d[i] : '0;
				offs_q[i] <= bias_q[i];
				gain_q[i] <= scale_q[i];
			end
			busy_q <= cal_q;
		end
	end

	// status to the controller
	always_comb begin
		sts.mode        = mode_q;
		sts.calibrating = cal_q;
		sts.div_done    = div_done;
		sts.out_free    = !out_valid_q || out_ready;
	end

	assign out_valid        = out_valid_q;
	assign corrected_x      = corr_q[0];
	assign corrected_y      = corr_q[1];
	assign corrected_z      = corr_q[2];
	assign offset_x_out     = offs_q[0];
	assign offset_y_out     = offs_q[1];
	assign offset_z_out     = offs_q[2];
	assign gain_x_out       = gain_q[0];
	assign gain_y_out       = gain_q[1];
	assign gain_z_out       = gain_q[2];
	assign busy_calibrating = busy_q;

endmodule

// ----- rtl/mmc_ctrl.sv -----
`timescale 1ns / 1ps
// calibrator controller: sequences each input beat through the datapath
// depends on mmc_pkg; drives dp_cmd_t, reads dp_sts_t
module mmc_ctrl import mmc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	axis_t  ax_q;

	// state register and fit axis counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ax_q    <= AXIS_X;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FIT_SUM) begin
				ax_q <= AXIS_X;
			end else if (state_q == ST_DIV_WAIT && sts.div_done) begin
				case (ax_q)
					AXIS_X:  ax_q <= AXIS_Y;
					AXIS_Y:  ax_q <= AXIS_Z;
					default: ax_q <= AXIS_X;
				endcase
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (sts.mode == MODE_STOP && sts.calibrating) begin
					state_d = ST_FIT_SUM;
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_FIT_SUM: state_d = ST_DIV_GO;
			ST_DIV_GO:  state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (sts.div_done) begin
					state_d = (ax_q == AXIS_Z) ? ST_RESP : ST_DIV_GO;
				end
			end
			ST_RESP: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		cmd.axis = ax_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_DISPATCH: begin
				case (sts.mode)
					MODE_CORRECT: cmd.mul       = 1'b1;
					MODE_ACCUM:   cmd.accum     = 1'b1;
					MODE_START:   cmd.start_cal = 1'b1;
					default: begin
						if (sts.calibrating) begin
							cmd.fit_half = 1'b1;
						end else begin
							cmd.stop_flag = 1'b1;
						end
					end
				endcase
			end
			ST_FIT_SUM: cmd.fit_sum   = 1'b1;
			ST_DIV_GO:  cmd.div_start = 1'b1;
			ST_DIV_WAIT: begin
				if (sts.div_done) begin
					cmd.div_write = 1'b1;
					cmd.stop_flag = (ax_q == AXIS_Z);
				end
			end
			ST_RESP: cmd.load_out = sts.out_free;
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	// divider results only arrive while the controller waits for them
	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> state_q == ST_DIV_WAIT)
		else $error("divider done outside wait state");

	// the output register is never overwritten while a beat is pending
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free)
		else $error("output loaded while previous beat pending");

	// the last axis of a fit ends the calibration run
	a_fit_clears_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_WAIT && sts.div_done && ax_q == AXIS_Z) |=> !sts.calibrating)
		else $error("calibrating flag still set after fit");
`endif

endmodule

// ----- rtl/three_axis_min_max_calibrator_top.sv -----
`timescale 1ns / 1ps
// Three-axis min/max calibrator. Each input beat carries a mode and an x/y/z sample and
// returns exactly one output beat with the corrected sample (zero unless the mode is
// correct), the current per-axis bias and Q2.14 scale, and the calibrating flag. One beat
// is handled at a time; a finished result sits in an output register, so the next input
// beat is taken while it waits. Correct, accumulate, start and a stop outside a run pass
// from acceptance through a dispatch state to the response state, which loads the result
// once the output register is free; the next beat is accepted in the cycle after the load.
// A stop that fits forms the fit sum and then runs the three scale divisions, one axis
// after the other, on one shared restoring divider that produces one quotient bit per
// cycle, before the response state.
// Depends on mmc_pkg, mmc_ctrl and mmc_dpath.
module three_axis_min_max_calibrator_top import mmc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] mode,
	input  sample_t    sample_x,
	input  sample_t    sample_y,
	input  sample_t    sample_z,
	output logic       out_valid,
	input  logic       out_ready,
	output corr_t      corrected_x,
	output corr_t      corrected_y,
	output corr_t      corrected_z,
	output sample_t    offset_x_out,
	output sample_t    offset_y_out,
	output sample_t    offset_z_out,
	output gain_t      gain_x_out,
	output gain_t      gain_y_out,
	output gain_t      gain_z_out,
	output logic       busy_calibrating
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencing
	mmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// arithmetic and state
	mmc_dpath u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.mode             (mode),
		.sample_x         (sample_x),
		.sample_y         (sample_y),
		.sample_z         (sample_z),
		.out_ready        (out_ready),
		.out_valid        (out_valid),
		.corrected_x      (corrected_x),
		.corrected_y      (corrected_y),
		.corrected_z      (corrected_z),
		.offset_x_out     (offset_x_out),
		.offset_y_out     (offset_y_out),
		.offset_z_out     (offset_z_out),
		.gain_x_out       (gain_x_out),
		.gain_y_out       (gain_y_out),
		.gain_z_out       (gain_z_out),
		.busy_calibrating (busy_calibrating)
	);

endmodule
